@@ src/sdcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcc_pkg
// Shared types and codes of the disparity consistency check.
// ----------------------------------------------------------------------------
package sdcc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LQ_THR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RQ_THR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_LQ      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_RQ      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT      = 3'd7;

    localparam logic [7:0] MASK_PASS   = 8'd0;
    localparam logic [7:0] MASK_REJECT = 8'd255;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef struct packed {
        logic               func;
        logic [7:0]         pixel_col;
        logic [7:0]         pixel_row;
        logic signed [23:0] line_disp;
        logic signed [23:0] samp_disp;
        logic [15:0]        quality;
    } t_in_word;

    typedef struct packed {
        logic [7:0] mask_value;
        logic [7:0] out_col;
        logic [7:0] out_row;
    } t_out_word;

    typedef struct packed {
        logic signed [23:0] line_map;
        logic signed [23:0] samp_map;
        logic [15:0]        quality;
    } t_entry;

endpackage

@@ src/sdcc_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcc_bank
// One parity bank of the right disparity store, single port, registered read.
// ----------------------------------------------------------------------------
module sdcc_bank #(
    parameter int AW = 14
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic            i_we,
    input  logic [AW-1:0]   i_addr,
    input  sdcc_pkg::t_entry i_wdata,
    output sdcc_pkg::t_entry o_rdata
);

    sdcc_pkg::t_entry r_mem [2**AW];
    sdcc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/stereo_disparity_consistency_check_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_disparity_consistency_check_unit
// Left/right disparity consistency check over a banked right disparity store.
// ----------------------------------------------------------------------------
// Input words carry func: a load word writes one right store entry and gives
// no result; a check word gives one result word (mask 0 or 255, col, row).
// The store is split into four banks by row and column parity, so the 2x2
// neighbourhood of a check reads in one access; a word enters every cycle unless stalled.
// A check passes through the stage registers in turn before it shows on o_valid.
// Throughput: one word per cycle while not stalled, set by the single port of each bank.
// A load followed directly by a check of the same entry sees the new data.
// Reset clears the pipeline valid bits and the configuration registers to their
// defaults; the store is undefined until loaded. While the receiver stalls a waiting
// result, the whole pipeline holds and o_stall is raised; nothing is lost.
// The user writes configuration on the cfg port only while idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module stereo_disparity_consistency_check_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  sdcc_pkg::t_in_word                  i_in,
    output logic                                o_valid,
    input  logic                                i_stall,
    output sdcc_pkg::t_out_word                 o_out,
    input  logic                                i_cfg_we,
    input  logic [sdcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sdcc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int AW  = CW - 1 + RW - 1;
    localparam int TW  = 26 + F;
    localparam int VW  = 28 + 2 * F;
    localparam int DFW = 30 + 3 * F;
    localparam int DW  = 16 + 2 * F;
    localparam int H   = (DW + 1) / 2;
    localparam int SW  = 2 * DW + 2;
    localparam logic signed [31:0] ONE_S = 32'sd1 <<< F;
    localparam logic [F:0]         ONE_U = (F+1)'(1) << F;

    // configuration
    logic [15:0] r_accept_dist, r_outlier, r_lq_thr, r_rq_thr;
    logic        r_use_lq, r_use_rq;
    logic [8:0]  r_width, r_height;
    logic [31:0] r_min_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_dist <= 16'd256;
            r_outlier     <= 16'd256;
            r_lq_thr      <= 16'd0;
            r_rq_thr      <= 16'd0;
            r_use_lq      <= 1'b0;
            r_use_rq      <= 1'b0;
            r_width       <= 9'd256;
            r_height      <= 9'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sdcc_pkg::CFG_ACCEPT_DIST: r_accept_dist <= i_cfg_data;
                sdcc_pkg::CFG_OUTLIER:     r_outlier     <= i_cfg_data;
                sdcc_pkg::CFG_LQ_THR:      r_lq_thr      <= i_cfg_data;
                sdcc_pkg::CFG_RQ_THR:      r_rq_thr      <= i_cfg_data;
                sdcc_pkg::CFG_USE_LQ:      r_use_lq      <= i_cfg_data[0];
                sdcc_pkg::CFG_USE_RQ:      r_use_rq      <= i_cfg_data[0];
                sdcc_pkg::CFG_WIDTH:       r_width       <= i_cfg_data[8:0];
                sdcc_pkg::CFG_HEIGHT:      r_height      <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_sq <= r_accept_dist * r_accept_dist;
    end

    // pipeline control
    logic [7:1] r_v;
    logic       advance, acc;

    assign advance = !(r_v[7] && i_stall);
    assign o_stall = !advance;
    assign acc     = i_valid && advance;

    // stage 0: range and left quality tests, bank addresses
    logic [12:0]        w_sat, h_sat;
    logic signed [31:0] sd32, ld32, lim_s, lim_l, ts32, tl32;
    logic               in_range, lq_bad;
    logic [CW-1:0]      ts, ts1;
    logic [RW-1:0]      tl, tl1;
    logic [15:0]        lcol16, lrow16;
    logic               in_store;
    logic [AW-1:0]      waddr;
    logic [1:0]         wbank;
    sdcc_pkg::t_entry   wentry;
    sdcc_pkg::t_entry   rd [4];

    always_comb begin
        w_sat    = (r_width > 9'(MAX_WIDTH)) || (MAX_WIDTH < 256 && r_width > 9'(MAX_WIDTH))
                   ? 13'(MAX_WIDTH) : 13'(r_width);
        if (MAX_WIDTH > 511) w_sat = 13'(r_width);
        h_sat    = (r_height > 9'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(r_height);
        if (MAX_HEIGHT > 511) h_sat = 13'(r_height);
        sd32     = 32'(i_in.samp_disp);
        ld32     = 32'(i_in.line_disp);
        lim_s    = ($signed({19'd0, w_sat}) - 32'sd2) <<< F;
        lim_l    = ($signed({19'd0, h_sat}) - 32'sd2) <<< F;
        in_range = sd32 >= ONE_S && sd32 <= lim_s && ld32 >= ONE_S && ld32 <= lim_l;
        lq_bad   = r_use_lq && (i_in.quality < r_lq_thr);
        ts32     = sd32 >>> F;
        tl32     = ld32 >>> F;
        ts       = ts32[CW-1:0];
        tl       = tl32[RW-1:0];
        ts1      = ts + 1'b1;
        tl1      = tl + 1'b1;
        lcol16   = 16'(i_in.pixel_col);
        lrow16   = 16'(i_in.pixel_row);
        in_store = (32'(lcol16) < MAX_WIDTH) && (32'(lrow16) < MAX_HEIGHT);
        waddr    = {lrow16[RW-1:1], lcol16[CW-1:1]};
        wbank    = {i_in.pixel_row[0], i_in.pixel_col[0]};
        wentry   = '{line_map: i_in.line_disp, samp_map: i_in.samp_disp,
                     quality: i_in.quality};
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BSEL = 2'(b);
        logic [CW-1:0] rcol;
        logic [RW-1:0] rrow;
        logic          we;
        logic [AW-1:0] addr;

        assign rcol = (ts[0] == BSEL[0]) ? ts : ts1;
        assign rrow = (tl[0] == BSEL[1]) ? tl : tl1;
        assign we   = acc && (i_in.func == sdcc_pkg::FUNC_LOAD) && in_store
                      && (wbank == BSEL);
        assign addr = we ? waddr : {rrow[RW-1:1], rcol[CW-1:1]};

        sdcc_bank #(.AW(AW)) u_bank (
            .i_clk   (i_clk),
            .i_en    (advance),
            .i_we    (we),
            .i_addr  (addr),
            .i_wdata (wentry),
            .o_rdata (rd[b])
        );
    end

    // stage 1
    logic         r1_rej, r1_sp, r1_lp;
    logic [7:0]   r1_col, r1_row;
    logic [F-1:0] r1_wr, r1_wb;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_rej <= lq_bad || !in_range;
            r1_col <= i_in.pixel_col;
            r1_row <= i_in.pixel_row;
            r1_wr  <= sd32[F-1:0];
            r1_wb  <= ld32[F-1:0];
            r1_sp  <= ts[0];
            r1_lp  <= tl[0];
        end
    end

    // stage 2: route neighbours, quality and outlier tests
    function automatic logic far_off(logic signed [23:0] a, logic signed [23:0] b,
                                     logic [15:0] t);
        logic signed [24:0] d;
        logic [24:0]        ad;
        d  = {a[23], a} - {b[23], b};
        ad = d[24] ? 25'(-d) : 25'(d);
        return ad > {9'd0, t};
    endfunction

    sdcc_pkg::t_entry e00, e01, e10, e11;
    logic             rq_bad, outl;

    always_comb begin
        e00    = rd[{r1_lp, r1_sp}];
        e01    = rd[{r1_lp, !r1_sp}];
        e10    = rd[{!r1_lp, r1_sp}];
        e11    = rd[{!r1_lp, !r1_sp}];
        rq_bad = r_use_rq && (e00.quality < r_rq_thr || e01.quality < r_rq_thr ||
                              e10.quality < r_rq_thr || e11.quality < r_rq_thr);
        outl   = far_off(e00.samp_map, e01.samp_map, r_outlier) ||
                 far_off(e00.samp_map, e10.samp_map, r_outlier) ||
                 far_off(e00.samp_map, e11.samp_map, r_outlier) ||
                 far_off(e00.line_map, e01.line_map, r_outlier) ||
                 far_off(e00.line_map, e10.line_map, r_outlier) ||
                 far_off(e00.line_map, e11.line_map, r_outlier);
    end

    logic               r2_rej;
    logic [7:0]         r2_col, r2_row;
    logic [F-1:0]       r2_wr, r2_wb;
    logic signed [23:0] r2_s00, r2_s01, r2_s10, r2_s11;
    logic signed [23:0] r2_l00, r2_l01, r2_l10, r2_l11;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r2_rej <= r1_rej || rq_bad || outl;
            r2_col <= r1_col;
            r2_row <= r1_row;
            r2_wr  <= r1_wr;
            r2_wb  <= r1_wb;
            r2_s00 <= e00.samp_map;
            r2_s01 <= e01.samp_map;
            r2_s10 <= e10.samp_map;
            r2_s11 <= e11.samp_map;
            r2_l00 <= e00.line_map;
            r2_l01 <= e01.line_map;
            r2_l10 <= e10.line_map;
            r2_l11 <= e11.line_map;
        end
    end

    // stage 3: horizontal blend
    logic signed [F+1:0] wls, wrs;
    logic signed [TW-1:0] n3_ts, n3_bs, n3_tl, n3_bl;

    always_comb begin
        wls   = $signed({1'b0, ONE_U - {1'b0, r2_wr}});
        wrs   = $signed({2'b0, r2_wr});
        n3_ts = wls * r2_s00 + wrs * r2_s01;
        n3_bs = wls * r2_s10 + wrs * r2_s11;
        n3_tl = wls * r2_l00 + wrs * r2_l01;
        n3_bl = wls * r2_l10 + wrs * r2_l11;
    end

    logic                 r3_rej;
    logic [7:0]           r3_col, r3_row;
    logic [F-1:0]         r3_wb;
    logic signed [TW-1:0] r3_ts, r3_bs, r3_tl, r3_bl;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r3_rej <= r2_rej;
            r3_col <= r2_col;
            r3_row <= r2_row;
            r3_wb  <= r2_wb;
            r3_ts  <= n3_ts;
            r3_bs  <= n3_bs;
            r3_tl  <= n3_tl;
            r3_bl  <= n3_bl;
        end
    end

    // stage 4: vertical blend
    logic signed [F+1:0]  wts, wbs;
    logic signed [VW-1:0] n4_vs, n4_vl;

    always_comb begin
        wts   = $signed({1'b0, ONE_U - {1'b0, r3_wb}});
        wbs   = $signed({2'b0, r3_wb});
        n4_vs = r3_ts * wts + r3_bs * wbs;
        n4_vl = r3_tl * wts + r3_bl * wbs;
    end

    logic                 r4_rej;
    logic [7:0]           r4_col, r4_row;
    logic signed [VW-1:0] r4_vs, r4_vl;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r4_rej <= r3_rej;
            r4_col <= r3_col;
            r4_row <= r3_row;
            r4_vs  <= n4_vs;
            r4_vl  <= n4_vl;
        end
    end

    // stage 5: round-trip distance per axis
    logic signed [DFW-1:0] d5x, d5y;
    logic [DFW-1:0]        a5x, a5y, m5;
    logic                  far5;

    always_comb begin
        d5x  = DFW'(r4_vs) - $signed({1'b0, r4_col, {(3*F){1'b0}}});
        d5y  = DFW'(r4_vl) - $signed({1'b0, r4_row, {(3*F){1'b0}}});
        a5x  = d5x[DFW-1] ? DFW'(-d5x) : DFW'(d5x);
        a5y  = d5y[DFW-1] ? DFW'(-d5y) : DFW'(d5y);
        m5   = {{(DFW-DW){1'b0}}, r_accept_dist, {(2*F){1'b0}}};
        far5 = (a5x >= m5) || (a5y >= m5);
    end

    logic          r5_rej;
    logic [7:0]    r5_col, r5_row;
    logic [DW-1:0] r5_dx, r5_dy;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r5_rej <= r4_rej || far5;
            r5_col <= r4_col;
            r5_row <= r4_row;
            r5_dx  <= a5x[DW-1:0];
            r5_dy  <= a5y[DW-1:0];
        end
    end

    // stage 6: partial products of the squares
    logic                  r6_rej;
    logic [7:0]            r6_col, r6_row;
    logic [2*(DW-H)-1:0]   r6_xhh, r6_yhh;
    logic [DW-1:0]         r6_xhl, r6_yhl;
    logic [2*H-1:0]        r6_xll, r6_yll;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r6_rej <= r5_rej;
            r6_col <= r5_col;
            r6_row <= r5_row;
            r6_xhh <= r5_dx[DW-1:H] * r5_dx[DW-1:H];
            r6_xhl <= r5_dx[DW-1:H] * r5_dx[H-1:0];
            r6_xll <= r5_dx[H-1:0] * r5_dx[H-1:0];
            r6_yhh <= r5_dy[DW-1:H] * r5_dy[DW-1:H];
            r6_yhl <= r5_dy[DW-1:H] * r5_dy[H-1:0];
            r6_yll <= r5_dy[H-1:0] * r5_dy[H-1:0];
        end
    end

    // stage 7: sum of squares against squared limit
    logic [SW-1:0] sq7, msq7;

    always_comb begin
        sq7  = (SW'(r6_xhh) << (2*H)) + (SW'(r6_xhl) << (H+1)) + SW'(r6_xll)
             + (SW'(r6_yhh) << (2*H)) + (SW'(r6_yhl) << (H+1)) + SW'(r6_yll);
        msq7 = SW'({r_min_sq, {(4*F){1'b0}}});
    end

    logic       r7_rej;
    logic [7:0] r7_col, r7_row;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r7_rej <= r6_rej || !(sq7 < msq7);
            r7_col <= r6_col;
            r7_row <= r6_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (advance) begin
            r_v <= {r_v[6:1], acc && (i_in.func == sdcc_pkg::FUNC_CHECK)};
        end
    end

    assign o_valid = r_v[7];
    assign o_out   = '{mask_value: r7_rej ? sdcc_pkg::MASK_REJECT : sdcc_pkg::MASK_PASS,
                       out_col: r7_col, out_row: r7_row};

endmodule

@@ src/sdcc_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcc_check
// Port-level checks of the consistency check unit, bound to the top level.
// ----------------------------------------------------------------------------
module sdcc_check (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input sdcc_pkg::t_out_word o_out
);

    a_mask_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.mask_value == sdcc_pkg::MASK_PASS ||
                     o_out.mask_value == sdcc_pkg::MASK_REJECT))
        else $error("mask code out of set");

    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output stall");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out)))
        else $error("stalled result word changed");

endmodule

bind stereo_disparity_consistency_check_unit sdcc_check u_sdcc_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_out   (o_out)
);
